>>> hw/rtl/ufsd_pkg.sv
`timescale 1ns / 1ps

package ufsd_pkg;

  localparam int unsigned UNIT_W      = 21;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [UNIT_W-1:0] REPL_CP   = 21'h00FFFD;
  localparam logic [UNIT_W-1:0] MAX_CP    = 21'h10FFFF;
  localparam logic [UNIT_W-1:0] SURR_LO   = 21'h00D800;
  localparam logic [UNIT_W-1:0] SURR_HI   = 21'h00DFFF;
  localparam logic [UNIT_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [UNIT_W-1:0] LOW_SURR  = 21'h00DC00;
  localparam logic [UNIT_W-1:0] BMP_MAX   = 21'h00FFFF;
  localparam logic [UNIT_W-1:0] MIN_LEN2  = 21'h000080;
  localparam logic [UNIT_W-1:0] MIN_LEN3  = 21'h000800;
  localparam logic [UNIT_W-1:0] MIN_LEN4  = 21'h010000;

  // One queued command: a run of substituted U+FFFD, then an optional
  // trailing code point that the back end may split into a surrogate pair.
  typedef struct packed {
    logic [1:0]        n_repl;
    logic              has_tail;
    logic              tail_repl;
    logic [UNIT_W-1:0] tail_cp;
  } cmd_t;

endpackage

>>> hw/rtl/ufsd_front.sv
`timescale 1ns / 1ps

module ufsd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  output logic                cmd_valid,
  output ufsd_pkg::cmd_t      cmd
);
  import ufsd_pkg::*;

  logic [2:0]        expected_len;
  logic [1:0]        bytes_seen;
  logic [UNIT_W-1:0] accum_bits;
  logic [2:0]        expected_len_next;
  logic [1:0]        bytes_seen_next;
  logic [UNIT_W-1:0] accum_bits_next;

  logic              lead_emit;
  logic              lead_repl;
  logic [UNIT_W-1:0] lead_cp;
  logic [2:0]        lead_len;
  logic [UNIT_W-1:0] lead_bits;
  logic [2:0]        seen_inc;
  logic [UNIT_W-1:0] accum_cat;
  logic [UNIT_W-1:0] min_value;
  logic              value_bad;

  // Decode of the byte taken as the first byte of a character.
  always_comb begin
    lead_len  = 3'd0;
    lead_bits = '0;
    if (text_byte inside {[8'hC0:8'hDF]}) begin
      lead_len  = 3'd2;
      lead_bits = {16'd0, text_byte[4:0]};
    end else if (text_byte inside {[8'hE0:8'hEF]}) begin
      lead_len  = 3'd3;
      lead_bits = {17'd0, text_byte[3:0]};
    end else if (text_byte inside {[8'hF0:8'hF7]}) begin
      lead_len  = 3'd4;
      lead_bits = {18'd0, text_byte[2:0]};
    end
    lead_emit = 1'b1;
    lead_repl = 1'b0;
    lead_cp   = {13'd0, text_byte};
    if (!text_byte[7]) begin
      lead_emit = 1'b1;
    end else if (lead_len == 3'd0 || end_of_text) begin
      lead_repl = 1'b1;
      lead_cp   = REPL_CP;
    end else begin
      lead_emit = 1'b0;
    end
  end

  always_comb begin
    seen_inc  = {1'b0, bytes_seen} + 3'd1;
    accum_cat = {accum_bits[UNIT_W-7:0], text_byte[5:0]};
    case (expected_len)
      3'd2:    min_value = MIN_LEN2;
      3'd3:    min_value = MIN_LEN3;
      3'd4:    min_value = MIN_LEN4;
      default: min_value = '0;
    endcase
    value_bad = (accum_cat < min_value) || (accum_cat > MAX_CP) ||
                (accum_cat >= SURR_LO && accum_cat <= SURR_HI);
  end

  always_comb begin
    expected_len_next = expected_len;
    bytes_seen_next   = bytes_seen;
    accum_bits_next   = accum_bits;
    cmd               = '0;
    if (expected_len == 3'd0 || text_byte[7:6] != 2'b10) begin
      // Lead byte, possibly after flushing a broken sequence.
      cmd.n_repl    = (expected_len == 3'd0) ? 2'd0 : bytes_seen;
      cmd.has_tail  = lead_emit;
      cmd.tail_repl = lead_repl;
      cmd.tail_cp   = lead_cp;
      if (lead_emit) begin
        expected_len_next = 3'd0;
        bytes_seen_next   = 2'd0;
        accum_bits_next   = '0;
      end else begin
        expected_len_next = lead_len;
        bytes_seen_next   = 2'd1;
        accum_bits_next   = lead_bits;
      end
    end else if (seen_inc >= expected_len) begin
      cmd.has_tail      = 1'b1;
      cmd.tail_repl     = value_bad;
      cmd.tail_cp       = value_bad ? REPL_CP : accum_cat;
      expected_len_next = 3'd0;
      bytes_seen_next   = 2'd0;
      accum_bits_next   = '0;
    end else if (end_of_text) begin
      cmd.n_repl        = seen_inc[1:0];
      expected_len_next = 3'd0;
      bytes_seen_next   = 2'd0;
      accum_bits_next   = '0;
    end else begin
      bytes_seen_next = seen_inc[1:0];
      accum_bits_next = accum_cat;
    end
    cmd_valid = take && (cmd.has_tail || cmd.n_repl != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_len <= 3'd0;
      bytes_seen   <= 2'd0;
      accum_bits   <= '0;
    end else if (take) begin
      expected_len <= expected_len_next;
      bytes_seen   <= bytes_seen_next;
      accum_bits   <= accum_bits_next;
    end
  end

endmodule

>>> hw/rtl/ufsd_queue.sv
`timescale 1ns / 1ps

module ufsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  input  ufsd_pkg::cmd_t wr_data,
  output logic           has_space,
  output logic           rd_valid,
  input  logic           rd_pop,
  output ufsd_pkg::cmd_t rd_data
);
  import ufsd_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign has_space = count != QUEUE_CW'(QUEUE_DEPTH);
  assign rd_valid  = count != '0;
  assign rd_data   = entries[rd_ptr];
  assign do_push   = wr_valid && has_space;
  assign do_pop    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/ufsd_back.sv
`timescale 1ns / 1ps

module ufsd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        utf16_mode,
  input  logic                        head_valid,
  input  ufsd_pkg::cmd_t              head,
  output logic                        head_pop,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [ufsd_pkg::UNIT_W-1:0] unit,
  output logic                        replaced,
  output logic                        run_last
);
  import ufsd_pkg::*;

  logic [1:0]        pos;
  logic              load;
  logic              tail_pair;
  logic [2:0]        total;
  logic [UNIT_W-1:0] supp;
  logic [UNIT_W-1:0] sel_unit;
  logic              sel_repl;
  logic              sel_last;

  assign load = !result_valid || result_ready;

  always_comb begin
    tail_pair = utf16_mode && head.has_tail && (head.tail_cp > BMP_MAX);
    total     = {1'b0, head.n_repl} + {2'b0, head.has_tail} + {2'b0, tail_pair};
    supp      = head.tail_cp - SUPP_BASE;
    if (pos < head.n_repl) begin
      sel_unit = REPL_CP;
      sel_repl = 1'b1;
    end else if (tail_pair && pos == head.n_repl) begin
      sel_unit = SURR_LO + {11'd0, supp[19:10]};
      sel_repl = head.tail_repl;
    end else if (tail_pair) begin
      sel_unit = LOW_SURR + {11'd0, supp[9:0]};
      sel_repl = head.tail_repl;
    end else begin
      sel_unit = head.tail_cp;
      sel_repl = head.tail_repl;
    end
    sel_last = ({1'b0, pos} + 3'd1) == total;
    head_pop = load && head_valid && sel_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pos          <= 2'd0;
    end else if (load) begin
      result_valid <= head_valid;
      if (head_valid) begin
        pos <= sel_last ? 2'd0 : pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      unit     <= sel_unit;
      replaced <= sel_repl;
      run_last <= sel_last;
    end
  end

endmodule

>>> hw/rtl/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake                    | Payload
// ---------+------------------------------+-----------------------------------
// text     | text_valid / text_ready      | text_byte[7:0], end_of_text
// result   | result_valid / result_ready  | unit[20:0], replaced, run_last
// cfg      | cfg_valid / cfg_ready        | cfg_data (utf16_mode)
//
// One byte is taken per cycle while the command queue has room; each byte
// yields zero to four result beats, delivered one per cycle while
// result_ready is high. A result passes through the command queue and
// then the output register before it leaves.
// Reset (rst, synchronous) clears the pending sequence, the queue, the
// output valid flag and the mode register (code points).
// A stall on the result side fills the four-entry queue before text_ready
// drops; a byte that produces nothing still needs a free entry to be taken.

module utf8_stream_decoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        text_valid,
  output logic                        text_ready,
  input  logic [7:0]                  text_byte,
  input  logic                        end_of_text,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [ufsd_pkg::UNIT_W-1:0] unit,
  output logic                        replaced,
  output logic                        run_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);
  import ufsd_pkg::*;

  logic utf16_mode;
  logic take;
  logic cmd_valid;
  cmd_t cmd;
  logic has_space;
  logic head_valid;
  logic head_pop;
  cmd_t head;

  // The mode register is always writable; the user must change it only while
  // the block is idle (not enforced here), so no sequence sees a mix of modes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      utf16_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      utf16_mode <= cfg_data;
    end
  end

  // A byte beat is taken only when the queue can hold whatever it produces.
  assign text_ready = has_space;
  assign take       = text_valid && text_ready;

  // Front end: tracks the multi-byte sequence and turns each byte that yields
  // output into a compact command (replacement count plus optional code point).
  ufsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  // Short queue that lets the front keep taking bytes while the back end
  // works through a multi-beat replacement run or waits on the sink.
  ufsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_valid  (cmd_valid),
    .wr_data   (cmd),
    .has_space (has_space),
    .rd_valid  (head_valid),
    .rd_pop    (head_pop),
    .rd_data   (head)
  );

  // Back end: expands each command into result beats, splitting
  // supplementary code points into surrogate pairs in UTF-16 mode.
  ufsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .utf16_mode   (utf16_mode),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .unit         (unit),
    .replaced     (replaced),
    .run_last     (run_last)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Checks the streaming UTF-8 decoder beat by beat. A predictor inside this
// module runs every accepted text byte through the same decode rules as the
// block and queues the code points or UTF-16 units that the byte must
// produce. A separate process takes every result beat and compares it with
// the oldest queued unit. The tests run in turn: directed code points, then
// surrogate pairs, then random text under several idling patterns, and
// finally a long stall on the result side.

module tb;

  import ufsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_UNITS      = 4;
  localparam int MAX_PRINTED    = 20;

  // One result beat: the unit, its substitution flag and the end-of-byte mark.
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              replaced;
    logic              run_last;
  } unit_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              text_valid = 1'b0;
  logic              text_ready;
  logic [7:0]        text_byte = 8'h00;
  logic              end_of_text = 1'b0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [UNIT_W-1:0] unit;
  logic              replaced;
  logic              run_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;

  utf8_stream_decoder_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .unit         (unit),
    .replaced     (replaced),
    .run_last     (run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state. It mirrors the decoder's partial sequence and the mode
  // register as the testbench last wrote it.
  logic              mode_utf16 = 1'b0;
  logic [2:0]        seq_len    = '0;
  logic [2:0]        seq_seen   = '0;
  logic [UNIT_W-1:0] seq_bits   = '0;

  unit_beat_t step_units[$];
  unit_beat_t expected_units[$];

  int  mismatches     = 0;
  int  bytes_sent     = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  logic rx_hold       = 1'b0;
  int  stall_cycles   = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The block never emits more than four beats per byte, so anything past
  // that is dropped, as it would be in the hardware queue entry.
  function automatic void emit_unit(logic [UNIT_W-1:0] u, logic rep);
    unit_beat_t r;
    if (step_units.size() >= MAX_UNITS) return;
    r.unit     = u;
    r.replaced = rep;
    r.run_last = 1'b0;
    step_units = {step_units, r};
  endfunction

  // In UTF-16 mode a code point above the basic plane leaves as a high and a
  // low surrogate, both carrying the same substitution flag.
  function automatic void emit_cp(logic [UNIT_W-1:0] cp, logic rep);
    logic [UNIT_W-1:0] offs;
    if (mode_utf16 && cp > BMP_MAX) begin
      offs = cp - SUPP_BASE;
      emit_unit(SURR_LO + (offs >> 10), rep);
      emit_unit(LOW_SURR + (offs & 21'h0003FF), rep);
    end else begin
      emit_unit(cp, rep);
    end
  endfunction

  function automatic void clear_seq();
    seq_len  = '0;
    seq_seen = '0;
    seq_bits = '0;
  endfunction

  // A byte seen at the start of a character. Lead bytes C0-F7 open a
  // sequence unless they carry the end-of-text flag; anything else that is
  // not ASCII is an invalid lead and becomes one substituted U+FFFD.
  function automatic void start_char(logic [7:0] b, logic eot);
    logic [2:0]        len;
    logic [UNIT_W-1:0] bits;
    len  = '0;
    bits = '0;
    if (b < 8'h80) begin
      emit_cp({13'd0, b}, 1'b0);
      return;
    end
    if (b[7:5] == 3'b110) begin
      len  = 3'd2;
      bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      len  = 3'd3;
      bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      len  = 3'd4;
      bits = {18'd0, b[2:0]};
    end
    if (len == 3'd0 || eot) begin
      emit_cp(REPL_CP, 1'b1);
      return;
    end
    seq_len  = len;
    seq_seen = 3'd1;
    seq_bits = bits;
  endfunction

  // Runs one accepted byte through the decode rules and queues every beat
  // that it must produce, with run_last on the final one.
  function automatic void decode_byte(logic [7:0] b, logic eot);
    logic [UNIT_W-1:0] min_cp;
    step_units.delete();
    if (seq_len == 3'd0) begin
      start_char(b, eot);
    end else if (b[7:6] == 2'b10) begin
      seq_bits = {seq_bits[UNIT_W-7:0], b[5:0]};
      seq_seen = seq_seen + 3'd1;
      if (seq_seen >= seq_len) begin
        case (seq_len)
          3'd2:    min_cp = MIN_LEN2;
          3'd3:    min_cp = MIN_LEN3;
          default: min_cp = MIN_LEN4;
        endcase
        // Overlong forms, values past the last plane and surrogate code
        // points are all replaced by a single U+FFFD.
        if (seq_bits < min_cp || seq_bits > MAX_CP ||
            (seq_bits >= SURR_LO && seq_bits <= SURR_HI))
          emit_cp(REPL_CP, 1'b1);
        else
          emit_cp(seq_bits, 1'b0);
        clear_seq();
      end else if (eot) begin
        // Text ends inside a sequence: one U+FFFD per byte taken so far.
        repeat (seq_seen) emit_cp(REPL_CP, 1'b1);
        clear_seq();
      end
    end else begin
      // A non-continuation byte breaks the sequence. The bytes taken so far
      // each become U+FFFD and the byte starts over as a lead.
      repeat (seq_seen) emit_cp(REPL_CP, 1'b1);
      clear_seq();
      start_char(b, eot);
    end
    if (step_units.size() > 0)
      step_units[step_units.size()-1].run_last = 1'b1;
    expected_units = {expected_units, step_units};
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // The ready pattern is redrawn every cycle. A long hold from the
  // back-pressure test overrides it.
  always @(posedge clk) begin
    result_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result beat is matched against the oldest expected unit. All
  // sampling happens right at the edge, so the values seen are the ones the
  // block presented before the edge.
  always @(posedge clk) begin
    unit_beat_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_units.size() == 0) begin
        report_mismatch($sformatf("unexpected beat unit=%h replaced=%b run_last=%b",
                                  unit, replaced, run_last));
      end else begin
        want = expected_units.pop_front();
        if (unit !== want.unit || replaced !== want.replaced ||
            run_last !== want.run_last)
          report_mismatch($sformatf(
            "unit=%h/%h replaced=%b/%b run_last=%b/%b (got/expected)",
            unit, want.unit, replaced, want.replaced, run_last, want.run_last));
      end
    end
  end

  // The watchdog restarts on any handshake. If nothing moves for the whole
  // limit, the block is considered hung.
  always @(posedge clk) begin
    if (rst || (text_valid && text_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Text side
  // ---------------------------------------------------------------------------

  // Offers one byte and holds it until the beat is taken. Idle cycles are
  // inserted before the byte at the current sender rate. The prediction is
  // made at the accepting edge, well ahead of the earliest result.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(3, 1) : 0;
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid  <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    do @(posedge clk); while (!text_ready);
    decode_byte(b, eot);
    bytes_sent++;
  endtask

  // Sends up to four bytes packed from the top of seq; the end-of-text flag
  // goes only on the last one.
  task automatic send_seq(input logic [31:0] seq, input int n, input logic eot_last);
    for (int i = 0; i < n; i++)
      send_byte(seq[31-8*i -: 8], eot_last && (i == n - 1));
  endtask

  // The sender pauses until every expected beat has arrived, then lets the
  // SETTLE_CYCLES settle period pass; bytes that produce nothing need a free
  // queue entry to be taken but never occupy one.
  task automatic drain_results();
    text_valid <= 1'b0;
    while (expected_units.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode changes are made only with the block idle.
  task automatic write_mode(input logic m);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    mode_utf16 = m;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // One random character. Most are well formed with random content so that
  // the decoder gets past the lead state; the rest are broken sequences and
  // raw noise.
  task automatic send_random_char();
    int                kind;
    int                n;
    logic [UNIT_W-1:0] cp;
    logic [31:0]       seq;
    kind = $urandom_range(99);
    if (kind < 30) begin
      send_byte(8'($urandom_range(8'h7F)), $urandom_range(19) == 0);
    end else if (kind < 70) begin
      n = $urandom_range(4, 2);
      case (n)
        2: begin
          cp  = 21'($urandom_range(21'h0007FF, 21'h000080));
          seq = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
        end
        3: begin
          cp  = 21'($urandom_range(21'h00FFFF, 21'h000800));
          seq = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
        end
        default: begin
          cp  = 21'($urandom_range(21'h10FFFF, 21'h010000));
          seq = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                 2'b10, cp[5:0]};
        end
      endcase
      send_seq(seq, n, $urandom_range(9) == 0);
    end else if (kind < 85) begin
      // Any lead with a random count of random continuations. This covers
      // overlong forms, surrogates, values past the last plane, short
      // sequences and, with the last byte replaced, broken continuations.
      n   = $urandom_range(3, 1);
      seq = {8'($urandom_range(8'hF7, 8'hC0)), 8'($urandom_range(8'hBF, 8'h80)),
             8'($urandom_range(8'hBF, 8'h80)), 8'($urandom_range(8'hBF, 8'h80))};
      if ($urandom_range(2) == 0) seq[31-8*n -: 8] = 8'($urandom_range(255));
      send_seq(seq, n + 1, $urandom_range(3) == 0);
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes and every error rule, with whole code points on the output.
  task automatic test_directed_code_points();
    write_mode(1'b0);
    set_idling(0, 0);
    send_seq(32'h00000000, 1, 1'b0);  // lowest ASCII
    send_seq(32'h7F000000, 1, 1'b1);  // highest ASCII, ends the text
    send_seq(32'hEFBFBD00, 3, 1'b0);  // U+FFFD encoded in the text, not replaced
    send_seq(32'hF0908080, 4, 1'b0);  // lowest four-byte value
    send_seq(32'h80000000, 1, 1'b0);  // continuation byte in lead position
    send_seq(32'hFF000000, 1, 1'b0);  // byte that can never appear
    send_seq(32'hC2000000, 1, 1'b1);  // lead on the last byte of the text
    send_seq(32'hF0908041, 4, 1'b0);  // broken after three bytes: four beats
    send_seq(32'hE0A00000, 2, 1'b1);  // text ends inside a sequence
    send_seq(32'hC0800000, 2, 1'b0);  // overlong two-byte form
    send_seq(32'hEDA08000, 3, 1'b0);  // surrogate code point
    send_seq(32'hF7BFBFBF, 4, 1'b0);  // value past the last plane
  endtask

  // Supplementary code points split into surrogate pairs.
  task automatic test_surrogate_pairs();
    write_mode(1'b1);
    send_seq(32'hF48FBFBF, 4, 1'b0);  // U+10FFFF as DBFF DFFF
    send_seq(32'hF0908080, 4, 1'b1);  // U+10000 as D800 DC00
    send_seq(32'hEFBFBF00, 3, 1'b0);  // U+FFFF stays a single unit
  endtask

  task automatic test_random_stream(input logic m, input int send_pct,
                                    input int recv_pct, input int n_bytes);
    int stop_at;
    write_mode(m);
    set_idling(send_pct, recv_pct);
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_char();
  endtask

  // The result side holds off for a long stretch while the text side keeps
  // offering bytes, so the command queue fills and text_ready drops. The
  // sender drops valid as soon as its last byte is taken and then waits for
  // every expected beat.
  task automatic test_backpressure();
    write_mode(1'b1);
    set_idling(0, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (80) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        repeat (12) send_random_char();
        drain_results();
      end
    join
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_code_points();
    test_surrogate_pairs();
    test_random_stream(1'b1, 0, 0, 50);
    test_random_stream(1'b0, 52, 0, 50);
    test_random_stream(1'b1, 0, 52, 50);
    test_random_stream(1'b0, 32, 32, 50);
    test_backpressure();

    // Final wait; the watchdog bounds it if beats go missing.
    drain_results();
    if (mismatches == 0 && expected_units.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
